### rtl/quad_rate_pid_motor_mixer_unit_macros.svh
// ---------------------------------------------------------------------------
// quad rate pid motor mixer assertion macros
// shared assertion forms, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef QUAD_RATE_PID_MOTOR_MIXER_UNIT_MACROS_SVH
`define QUAD_RATE_PID_MOTOR_MIXER_UNIT_MACROS_SVH

// same-cycle implication
`define QRPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QRPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qrpm_pkg.sv
// ---------------------------------------------------------------------------
// qrpm_pkg
// shared types and constants of the quad rate pid motor mixer
// ---------------------------------------------------------------------------
`default_nettype none

package qrpm_pkg;

    // item kinds
    localparam logic [1:0] CMD_STICK = 2'd0;
    localparam logic [1:0] CMD_GYRO  = 2'd1;
    localparam logic [1:0] CMD_SERVO = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_THROTTLE_TRIM = 3'd0;
    localparam logic [2:0] REG_AILERON_TRIM  = 3'd1;
    localparam logic [2:0] REG_ELEVATOR_TRIM = 3'd2;
    localparam logic [2:0] REG_RUDDER_TRIM   = 3'd3;
    localparam logic [2:0] REG_PITCH_GAINS   = 3'd4;
    localparam logic [2:0] REG_ROLL_GAINS    = 3'd5;
    localparam logic [2:0] REG_YAW_GAINS     = 3'd6;
    localparam logic [2:0] REG_MIX_CONTROL   = 3'd7;

    localparam int CFG_DATA_W = 52;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 112;

    // stick channel order: throttle, aileron, elevator, rudder
    localparam int CH_THROTTLE = 0;

    // axis order: pitch, roll, yaw; setpoint channel feeding each axis
    localparam int NUM_AXES = 3;
    localparam logic [1:0] AXIS_SETPOINT [NUM_AXES] = '{2'd2, 2'd1, 2'd3};
    localparam int AXIS_PITCH = 0;
    localparam int AXIS_ROLL  = 1;
    localparam int AXIS_YAW   = 2;

    // input request payload, lowest field in the lowest bits
    typedef struct packed {
        logic [3:0]        pad;
        logic [2:0][15:0]  rate;     // x pitch, y roll, z yaw
        logic [3:0][10:0]  raw;      // throttle, aileron, elevator, rudder
    } in_item_t;

    // result request payload
    typedef struct packed {
        logic [2:0][15:0]  corr;     // pitch, roll, yaw
        logic [3:0][15:0]  motor;    // front right, rear right, rear left, front left
    } out_item_t;

    // per-axis pid update
    typedef struct packed {
        logic [31:0] err;
        logic [31:0] sum;
        logic [15:0] corr;
    } pid_result_t;

    // mix_control fields
    typedef struct packed {
        logic [3:0]  motor_sel;
        logic [15:0] throttle_override;
        logic [15:0] test_width;
        logic [15:0] width_offset;
    } mix_ctrl_t;

endpackage

`default_nettype wire

### rtl/qrpm_stick.sv
// ---------------------------------------------------------------------------
// qrpm_stick
// offset and scale of one raw stick channel into a setpoint
// ---------------------------------------------------------------------------
`default_nettype none

module qrpm_stick (
    input  wire logic [10:0] raw,
    input  wire logic [31:0] trim,
    output logic      [31:0] setpoint
);

    logic [31:0] diff;

    always_comb
    begin
        diff     = {21'd0, raw} - {16'd0, trim[15:0]};
        setpoint = diff * {16'd0, trim[31:16]};
    end

endmodule

`default_nettype wire

### rtl/qrpm_pid_axis.sv
// ---------------------------------------------------------------------------
// qrpm_pid_axis
// one axis of the rate pid: error, integral, derivative and 16-bit shift
// ---------------------------------------------------------------------------
`default_nettype none

module qrpm_pid_axis (
    input  wire logic        [31:0] setpoint,
    input  wire logic signed [15:0] rate,
    input  wire logic        [47:0] gains,
    input  wire logic        [31:0] last_err,
    input  wire logic        [31:0] sum,
    output qrpm_pkg::pid_result_t   result
);

    logic [31:0] err;
    logic [31:0] sum_next;
    logic [31:0] p_term;
    logic [31:0] i_term;
    logic [31:0] d_term;
    logic [31:0] acc;

    always_comb
    begin
        err      = setpoint - {{16{rate[15]}}, rate};
        sum_next = sum + err;
        p_term   = err * {16'd0, gains[15:0]};
        i_term   = sum_next * {16'd0, gains[31:16]};
        d_term   = (err - last_err) * {16'd0, gains[47:32]};
        acc      = p_term + i_term + d_term;
        // arithmetic shift by 16 keeping the low 16 bits is just the top half
        result.err  = err;
        result.sum  = sum_next;
        result.corr = acc[31:16];
    end

endmodule

`default_nettype wire

### rtl/qrpm_mixer.sv
// ---------------------------------------------------------------------------
// qrpm_mixer
// x-frame mix of throttle and corrections into four motor widths
// ---------------------------------------------------------------------------
`default_nettype none

module qrpm_mixer (
    input  wire logic [15:0]        throttle,
    input  wire qrpm_pkg::mix_ctrl_t ctrl,
    input  wire logic [2:0][15:0]   corr,
    output logic      [3:0][15:0]   widths
);

    // the mix is computed in 16 bits, so only the low 16 bits of the sum reach the outputs
    logic [15:0] thr;
    logic [15:0] p;
    logic [15:0] r;
    logic [15:0] y;
    logic [3:0][15:0] mix;

    always_comb
    begin
        thr = (ctrl.throttle_override != 16'd0) ? ctrl.throttle_override : throttle;
        p   = corr[qrpm_pkg::AXIS_PITCH];
        r   = corr[qrpm_pkg::AXIS_ROLL];
        y   = corr[qrpm_pkg::AXIS_YAW];
        mix[0] = thr + r + p + y;
        mix[1] = thr + r - p - y;
        mix[2] = thr - r - p + y;
        mix[3] = thr - r + p - y;
        for (int i = 0; i < 4; i++)
        begin
            widths[i] = ctrl.motor_sel[i] ? ctrl.test_width : mix[i] + ctrl.width_offset;
        end
    end

endmodule

`default_nettype wire

### rtl/quad_rate_pid_motor_mixer_unit.sv
// ---------------------------------------------------------------------------
// quad_rate_pid_motor_mixer_unit
// rate pid for pitch, roll and yaw with x-frame motor mixing
// ---------------------------------------------------------------------------
// Takes one request per clock while m_tready is high and returns exactly
// one result request per input request, in order. A request is captured in
// an input register, then all of its work (stick scaling, the three per-axis
// pid updates, or the motor mix) is done in combinational logic that writes
// the controller state; that state doubles as the result register, so a
// result passes the input register and then the result register. The pid
// path is three 32x16 multiplies and a three-way add. While a result waits
// for m_tready, one more request is still taken into the input register.
// Every result carries the kind of its request in m_tuser plus the current
// motor widths and corrections. The user must write configuration through
// cfg_we/cfg_addr/cfg_data only while the unit is idle; the unit does not
// enforce this. There is no read-back. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module quad_rate_pid_motor_mixer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // throttle_raw[10:0], aileron_raw[21:11], elevator_raw[32:22],
    // rudder_raw[43:33], rate_x[59:44], rate_y[75:60], rate_z[91:76], zero pad
    input  wire logic [qrpm_pkg::IN_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // motor_front_right[15:0], motor_rear_right[31:16], motor_rear_left[47:32],
    // motor_front_left[63:48], pitch_correction[79:64],
    // roll_correction[95:80], yaw_correction[111:96]
    output logic [qrpm_pkg::OUT_DATA_W-1:0] m_tdata,
    // kind_echo[1:0]
    output logic [1:0]       m_tuser,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [qrpm_pkg::CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [3:0][31:0]     trim_reg;      // throttle, aileron, elevator, rudder
    logic [2:0][47:0]     gains_reg;     // pitch, roll, yaw
    qrpm_pkg::mix_ctrl_t  mix_ctrl_reg;

    // input register
    logic                 in_valid_reg;
    qrpm_pkg::in_item_t   in_item_reg;
    logic [1:0]           in_kind_reg;

    // controller state, also the result register
    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic [3:0][31:0]     setpoint_reg;
    logic [2:0][31:0]     last_err_reg;
    logic [2:0][31:0]     sum_reg;
    logic [2:0][15:0]     corr_reg;
    logic [3:0][15:0]     motor_reg;

    logic                 advance;
    logic                 fire;
    logic                 in_valid_next;
    logic                 out_valid_next;

    logic [3:0][31:0]     setpoint_next;
    qrpm_pkg::pid_result_t pid_res [qrpm_pkg::NUM_AXES];
    logic [3:0][15:0]     motor_next;

    qrpm_pkg::out_item_t  out_item;

    // handshake: the result slot frees when empty or being taken
    always_comb
    begin
        advance        = !out_valid_reg || m_tready;
        s_tready       = !in_valid_reg || advance;
        fire           = in_valid_reg && advance;
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = fire || (out_valid_reg && !m_tready);
    end

    // stick scaling, one unit per channel
    for (genvar c = 0; c < 4; c++)
    begin : g_stick
        qrpm_stick u_stick (
            .raw      (in_item_reg.raw[c]),
            .trim     (trim_reg[c]),
            .setpoint (setpoint_next[c])
        );
    end

    // per-axis pid, fed from the matching setpoint channel
    for (genvar a = 0; a < qrpm_pkg::NUM_AXES; a++)
    begin : g_pid
        qrpm_pid_axis u_pid (
            .setpoint (setpoint_reg[qrpm_pkg::AXIS_SETPOINT[a]]),
            .rate     (in_item_reg.rate[a]),
            .gains    (gains_reg[a]),
            .last_err (last_err_reg[a]),
            .sum      (sum_reg[a]),
            .result   (pid_res[a])
        );
    end

    qrpm_mixer u_mixer (
        .throttle (setpoint_reg[qrpm_pkg::CH_THROTTLE][15:0]),
        .ctrl     (mix_ctrl_reg),
        .corr     (corr_reg),
        .widths   (motor_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg      <= '0;
            gains_reg     <= '0;
            mix_ctrl_reg  <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= '0;
            setpoint_reg  <= '0;
            last_err_reg  <= '0;
            sum_reg       <= '0;
            corr_reg      <= '0;
            motor_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr) inside
                    qrpm_pkg::REG_THROTTLE_TRIM, qrpm_pkg::REG_AILERON_TRIM,
                    qrpm_pkg::REG_ELEVATOR_TRIM, qrpm_pkg::REG_RUDDER_TRIM:
                        trim_reg[cfg_addr[1:0]] <= cfg_data[31:0];
                    qrpm_pkg::REG_PITCH_GAINS:
                        gains_reg[qrpm_pkg::AXIS_PITCH] <= cfg_data[47:0];
                    qrpm_pkg::REG_ROLL_GAINS:
                        gains_reg[qrpm_pkg::AXIS_ROLL] <= cfg_data[47:0];
                    qrpm_pkg::REG_YAW_GAINS:
                        gains_reg[qrpm_pkg::AXIS_YAW] <= cfg_data[47:0];
                    qrpm_pkg::REG_MIX_CONTROL:
                        mix_ctrl_reg <= cfg_data;
                    default: ;
                endcase
            end

            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;

            if (fire)
            begin
                out_kind_reg <= in_kind_reg;
                case (in_kind_reg)
                    qrpm_pkg::CMD_STICK:
                        setpoint_reg <= setpoint_next;
                    qrpm_pkg::CMD_GYRO:
                    begin
                        for (int a = 0; a < qrpm_pkg::NUM_AXES; a++)
                        begin
                            last_err_reg[a] <= pid_res[a].err;
                            sum_reg[a]      <= pid_res[a].sum;
                            corr_reg[a]     <= pid_res[a].corr;
                        end
                    end
                    qrpm_pkg::CMD_SERVO:
                        motor_reg <= motor_next;
                    // unused kind leaves the state alone
                    default: ;
                endcase
            end
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= qrpm_pkg::in_item_t'(s_tdata);
            in_kind_reg <= s_tuser;
        end
    end

    always_comb
    begin
        out_item.corr  = corr_reg;
        out_item.motor = motor_reg;
        m_tvalid       = out_valid_reg;
        m_tuser        = out_kind_reg;
        m_tdata        = out_item;
    end

endmodule

`default_nettype wire

### rtl/qrpm_checker.sv
// ---------------------------------------------------------------------------
// qrpm_checker
// port-level checks of the quad rate pid motor mixer, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "quad_rate_pid_motor_mixer_unit_macros.svh"

module qrpm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [qrpm_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // last delivered motor widths and corrections, zero out of reset
    logic [63:0] last_motor_reg;
    logic [47:0] last_corr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_motor_reg <= '0;
            last_corr_reg  <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            last_motor_reg <= m_tdata[63:0];
            last_corr_reg  <= m_tdata[111:64];
        end
    end

    `QRPM_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // an empty result slot never blocks the input
    `QRPM_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready,
        "input blocked while no result pending")

    // only servo ticks move the motors
    `QRPM_ASSERT_IMP(a_motors_only_on_servo,
        m_tvalid && m_tuser != qrpm_pkg::CMD_SERVO,
        m_tdata[63:0] == last_motor_reg, "motor widths changed outside a servo tick")

    // only gyro samples move the corrections
    `QRPM_ASSERT_IMP(a_corr_only_on_gyro,
        m_tvalid && m_tuser != qrpm_pkg::CMD_GYRO,
        m_tdata[111:64] == last_corr_reg, "corrections changed outside a gyro sample")

endmodule

bind quad_rate_pid_motor_mixer_unit qrpm_checker u_qrpm_checker (.*);

`default_nettype wire

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for quad_rate_pid_motor_mixer_unit: a directed table of
// stick, gyro and servo requests and register writes, then random requests
// under several register settings and idle patterns, every result compared field by field
// against fixed values for some directed rows, else against an in-bench model of the rate controller
// ---------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 258;
    localparam int SETTLE_CYCLES  = 4;
    localparam int STALL_LIMIT    = 2000;
    localparam int PRINT_LIMIT    = 100;

    localparam int CFG_W = qrpm_pkg::CFG_DATA_W;

    // setpoint channel feeding each axis: elevator, aileron, rudder
    localparam int AXIS_CHANNEL [3] = '{2, 1, 3};

    typedef struct packed {
        logic [1:0]          kind;
        qrpm_pkg::out_item_t data;
    } mixer_result_t;

    typedef struct packed {
        logic                 is_write;
        logic [2:0]           reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [1:0]           kind;
        qrpm_pkg::in_item_t   payload;
        logic                 fixed;
        logic [15:0]          fixed_width;
    } stim_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [qrpm_pkg::IN_DATA_W-1:0]     s_tdata = '0;
    logic [1:0]                         s_tuser = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [qrpm_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic [1:0]                         m_tuser;
    logic                               cfg_we = 1'b0;
    logic [2:0]                         cfg_addr = '0;
    logic [CFG_W-1:0]                   cfg_data = '0;

    // model registers
    logic [31:0]         trim [4];
    logic [47:0]         gains [3];
    qrpm_pkg::mix_ctrl_t mix;

    // model state
    logic [31:0] setpt [4];
    logic [31:0] last_err [3];
    logic [31:0] err_sum [3];
    logic [15:0] corr [3];
    logic [15:0] width [4];

    mixer_result_t mixer_outputs [$];
    stim_row_t     directed_rows [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int stall_cycles = 0;

    quad_rate_pid_motor_mixer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // register write as seen by the model
    function automatic void apply_register(logic [2:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            qrpm_pkg::REG_THROTTLE_TRIM: trim[0] = val[31:0];
            qrpm_pkg::REG_AILERON_TRIM:  trim[1] = val[31:0];
            qrpm_pkg::REG_ELEVATOR_TRIM: trim[2] = val[31:0];
            qrpm_pkg::REG_RUDDER_TRIM:   trim[3] = val[31:0];
            qrpm_pkg::REG_PITCH_GAINS:   gains[qrpm_pkg::AXIS_PITCH] = val[47:0];
            qrpm_pkg::REG_ROLL_GAINS:    gains[qrpm_pkg::AXIS_ROLL] = val[47:0];
            qrpm_pkg::REG_YAW_GAINS:     gains[qrpm_pkg::AXIS_YAW] = val[47:0];
            qrpm_pkg::REG_MIX_CONTROL:   mix = val;
            default: ;
        endcase
    endfunction

    // advance the controller by one request and return the motor widths and
    // corrections that follow it
    function automatic qrpm_pkg::out_item_t controller_step(logic [1:0] kind,
                                                            qrpm_pkg::in_item_t req);
        qrpm_pkg::out_item_t res;
        logic [31:0] err;
        logic [31:0] acc;
        logic [31:0] thr;
        logic [31:0] p;
        logic [31:0] r;
        logic [31:0] y;
        logic [31:0] m [4];
        int          i;
        case (kind)
            qrpm_pkg::CMD_STICK: begin
                // (raw - offset) * scale, wrapping at 32 bits
                for (i = 0; i < 4; i++)
                    setpt[i] = ({21'd0, req.raw[i]} - {16'd0, trim[i][15:0]})
                               * {16'd0, trim[i][31:16]};
            end
            qrpm_pkg::CMD_GYRO: begin
                for (i = 0; i < 3; i++) begin
                    err = setpt[AXIS_CHANNEL[i]] - {{16{req.rate[i][15]}}, req.rate[i]};
                    err_sum[i] = err_sum[i] + err;
                    acc = err * {16'd0, gains[i][15:0]}
                          + err_sum[i] * {16'd0, gains[i][31:16]}
                          + (err - last_err[i]) * {16'd0, gains[i][47:32]};
                    last_err[i] = err;
                    // arithmetic shift by 16, low half kept
                    corr[i] = acc[31:16];
                end
            end
            qrpm_pkg::CMD_SERVO: begin
                // throttle test overrides the setpoint for this tick only
                thr = (mix.throttle_override != 16'd0) ? {16'd0, mix.throttle_override}
                                                       : setpt[0];
                p = {{16{corr[qrpm_pkg::AXIS_PITCH][15]}}, corr[qrpm_pkg::AXIS_PITCH]};
                r = {{16{corr[qrpm_pkg::AXIS_ROLL][15]}}, corr[qrpm_pkg::AXIS_ROLL]};
                y = {{16{corr[qrpm_pkg::AXIS_YAW][15]}}, corr[qrpm_pkg::AXIS_YAW]};
                m[0] = thr + r + p + y;
                m[1] = thr + r - p - y;
                m[2] = thr - r - p + y;
                m[3] = thr - r + p - y;
                for (i = 0; i < 4; i++)
                    width[i] = mix.motor_sel[i] ? mix.test_width
                                                : m[i][15:0] + mix.width_offset;
            end
            default: ;
        endcase
        for (i = 0; i < 4; i++)
            res.motor[i] = width[i];
        for (i = 0; i < 3; i++)
            res.corr[i] = corr[i];
        return res;
    endfunction

    function automatic void add_write(logic [2:0] idx, logic [CFG_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(logic [1:0] kind, int t, int a, int e, int r,
                                     int x, int y, int z,
                                     logic fixed, logic [15:0] fixed_width);
        stim_row_t row;
        row = '0;
        row.kind = kind;
        row.payload.raw[0] = t[10:0];
        row.payload.raw[1] = a[10:0];
        row.payload.raw[2] = e[10:0];
        row.payload.raw[3] = r[10:0];
        row.payload.rate[0] = x[15:0];
        row.payload.rate[1] = y[15:0];
        row.payload.rate[2] = z[15:0];
        row.fixed = fixed;
        row.fixed_width = fixed_width;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [10:0] pick_raw();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 11'd0;
        if (sel == 1)
            return 11'h7FF;
        return 11'($urandom);
    endfunction

    function automatic logic [15:0] pick_rate();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 16'h8000;
        if (sel == 1)
            return 16'h7FFF;
        if (sel < 6)
            return 16'($urandom_range(1000)) - 16'd500;
        return 16'($urandom);
    endfunction

    // gain or scale field of random magnitude
    function automatic logic [15:0] pick_gain_field();
        int bits;
        bits = $urandom_range(16);
        return 16'($urandom & ((32'h1 << bits) - 32'h1));
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("result %0d %s: got %h want %h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    // hold off requests until every result is back, then let the unit settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (mixer_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        apply_register(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(input logic [1:0] kind, input qrpm_pkg::in_item_t req,
                                input logic fixed, input logic [15:0] fixed_width);
        mixer_result_t       rec;
        qrpm_pkg::out_item_t pred;
        int                  i;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= req;
        s_tuser <= kind;
        do @(posedge clk); while (!s_tready);
        // request taken at this edge
        pred = controller_step(kind, req);
        rec.kind = kind;
        if (fixed) begin
            for (i = 0; i < 4; i++)
                rec.data.motor[i] = fixed_width;
            rec.data.corr = '0;
        end else begin
            rec.data = pred;
        end
        mixer_outputs.push_back(rec);
    endtask

    // result side: check each taken result, random back-pressure
    always @(posedge clk) begin : result_check
        mixer_result_t       want;
        qrpm_pkg::out_item_t got;
        int                  i;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (mixer_outputs.size() == 0) begin
                report_mismatch("result with no request pending", {14'd0, m_tuser}, 16'd0);
            end else begin
                want = mixer_outputs.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind_echo", {14'd0, m_tuser}, {14'd0, want.kind});
                for (i = 0; i < 4; i++)
                    if (got.motor[i] !== want.data.motor[i])
                        report_mismatch($sformatf("motor width %0d", i),
                                        got.motor[i], want.data.motor[i]);
                for (i = 0; i < 3; i++)
                    if (got.corr[i] !== want.data.corr[i])
                        report_mismatch($sformatf("correction axis %0d", i),
                                        got.corr[i], want.data.corr[i]);
            end
            results_seen++;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        qrpm_pkg::in_item_t req;
        logic [1:0]         kind;
        logic [CFG_W-1:0]   val;
        logic [15:0]        offset;
        int                 n;
        int                 k;
        int                 ph;
        int                 pick;

        for (k = 0; k < 4; k++) begin
            trim[k] = '0;
            setpt[k] = '0;
            width[k] = '0;
        end
        for (k = 0; k < 3; k++) begin
            gains[k] = '0;
            last_err[k] = '0;
            err_sum[k] = '0;
            corr[k] = '0;
        end
        mix = '0;

        // after reset every register is zero, so all outputs stay zero
        add_item(qrpm_pkg::CMD_STICK, 2047, 2047, 2047, 2047, 0, 0, 0, 1'b1, 16'h0000);
        add_item(qrpm_pkg::CMD_GYRO, 0, 0, 0, 0, -32768, 32767, -1, 1'b1, 16'h0000);
        add_item(qrpm_pkg::CMD_SERVO, 0, 0, 0, 0, 0, 0, 0, 1'b1, 16'h0000);
        add_item(CMD_UNUSED, 5, 6, 7, 8, 9, 10, 11, 1'b1, 16'h0000);
        // every motor selected: all take the test width
        add_write(qrpm_pkg::REG_MIX_CONTROL, {4'hF, 16'h0000, 16'hBEEF, 16'h0000});
        add_item(qrpm_pkg::CMD_SERVO, 0, 0, 0, 0, 0, 0, 0, 1'b1, 16'hBEEF);
        // extreme trims and gains
        add_write(qrpm_pkg::REG_THROTTLE_TRIM, 32'hFFFF_FFFF);
        add_write(qrpm_pkg::REG_AILERON_TRIM, 32'h0001_0000);
        add_write(qrpm_pkg::REG_ELEVATOR_TRIM, 32'h0003_0400);
        add_write(qrpm_pkg::REG_RUDDER_TRIM, 32'hFFFF_0000);
        add_write(qrpm_pkg::REG_PITCH_GAINS, 48'hFFFF_FFFF_FFFF);
        add_write(qrpm_pkg::REG_ROLL_GAINS, 48'h0001_0100_4000);
        add_write(qrpm_pkg::REG_YAW_GAINS, 48'h0000_0000_8000);
        add_write(qrpm_pkg::REG_MIX_CONTROL, {4'h0, 16'h0000, 16'h0000, 16'h03E8});
        add_item(qrpm_pkg::CMD_STICK, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'h0000);
        add_item(qrpm_pkg::CMD_STICK, 2047, 2047, 2047, 2047, 0, 0, 0, 1'b0, 16'h0000);
        add_item(qrpm_pkg::CMD_GYRO, 0, 0, 0, 0, 32767, -32768, 0, 1'b0, 16'h0000);
        add_item(qrpm_pkg::CMD_GYRO, 0, 0, 0, 0, -32768, 32767, 32767, 1'b0, 16'h0000);
        add_item(qrpm_pkg::CMD_GYRO, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'h0000);
        add_item(qrpm_pkg::CMD_SERVO, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'h0000);
        add_item(qrpm_pkg::CMD_STICK, 1024, 1023, 1024, 1, 0, 0, 0, 1'b0, 16'h0000);
        add_item(qrpm_pkg::CMD_GYRO, 0, 0, 0, 0, 100, -100, 5, 1'b0, 16'h0000);
        add_item(qrpm_pkg::CMD_SERVO, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'h0000);
        // unused kind leaves the state alone
        add_item(CMD_UNUSED, 2047, 0, 2047, 0, -1, 1, -1, 1'b0, 16'h0000);
        // throttle test with some motors selected
        add_write(qrpm_pkg::REG_MIX_CONTROL, {4'b0101, 16'hFFFF, 16'h1234, 16'hFFFF});
        add_item(qrpm_pkg::CMD_SERVO, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'h0000);
        add_write(qrpm_pkg::REG_MIX_CONTROL, {4'b1010, 16'h0001, 16'h0000, 16'h0000});
        add_item(qrpm_pkg::CMD_SERVO, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'h0000);
        // fields of the other kinds are ignored
        add_item(qrpm_pkg::CMD_GYRO, 2047, 2047, 2047, 2047, 1, 2, 3, 1'b0, 16'h0000);
        add_item(qrpm_pkg::CMD_SERVO, 2047, 2047, 2047, 2047, -32768, -32768, -32768,
                 1'b0, 16'h0000);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < directed_rows.size(); n++) begin
            if (directed_rows[n].is_write) begin
                drain_results();
                write_register(directed_rows[n].reg_idx, directed_rows[n].reg_val);
            end else begin
                send_request(directed_rows[n].kind, directed_rows[n].payload,
                             directed_rows[n].fixed, directed_rows[n].fixed_width);
            end
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            // slow sender and busy receiver, then the reverse, then full rate
            send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 85 : 0;
            recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 37 : 0;

            // new register setting: all registers first time, a subset later
            for (k = 0; k < 8; k++) begin
                if (ph == 0 || $urandom_range(1) == 1) begin
                    pick = $urandom_range(9);
                    offset = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2047));
                    case (k)
                        qrpm_pkg::REG_PITCH_GAINS, qrpm_pkg::REG_ROLL_GAINS,
                        qrpm_pkg::REG_YAW_GAINS:
                            val = (pick == 0) ? 52'h0_FFFF_FFFF_FFFF
                                              : {4'h0, pick_gain_field(), pick_gain_field(),
                                                 pick_gain_field()};
                        qrpm_pkg::REG_MIX_CONTROL:
                            val = (pick == 0) ? 52'hF_FFFF_FFFF_FFFF
                                              : {($urandom_range(1) ? 4'($urandom) : 4'h0),
                                                 ($urandom_range(2) == 0 ? 16'($urandom)
                                                                         : 16'h0000),
                                                 16'($urandom), 16'($urandom)};
                        default:
                            val = (pick == 0) ? 52'h0_0000_FFFF_FFFF
                                              : {20'h0, pick_gain_field(), offset};
                    endcase
                    if (pick == 1)
                        val = '0;
                    write_register(3'(k), val);
                end
            end

            for (n = 0; n < PHASE_REQUESTS; n++) begin
                // one pause until every result has come back
                if (ph == 0 && n == PHASE_REQUESTS / 2)
                    drain_results();
                pick = $urandom_range(99);
                kind = (pick < 25) ? qrpm_pkg::CMD_STICK
                     : (pick < 65) ? qrpm_pkg::CMD_GYRO
                     : (pick < 95) ? qrpm_pkg::CMD_SERVO : CMD_UNUSED;
                req = '0;
                for (k = 0; k < 4; k++)
                    req.raw[k] = pick_raw();
                for (k = 0; k < 3; k++)
                    req.rate[k] = pick_rate();
                send_request(kind, req, 1'b0, 16'h0000);
            end
        end

        drain_results();
        if (mismatch_count == 0 && mixer_outputs.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
